/* rtl/bia_pkg.sv */
// ----------------------------------------------------------------------------
// bia_pkg
// Shared types and constants for the bitmap index allocator.
// ----------------------------------------------------------------------------
package bia_pkg;

  // field widths of the stream words
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned S_DATA_W = 16;
  localparam int unsigned M_DATA_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_MARK    = 2'd2,
    OP_QUERY   = 2'd3
  } bia_op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_RESP
  } bia_state_e;

endpackage

/* rtl/bitmap_index_allocator_core.sv */
// ----------------------------------------------------------------------------
// bitmap_index_allocator_core
// First-fit index allocator over a bitmap held in a word-wide memory.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one command word: tuser = operation, tdata = index.
//   Master stream returns one result word per command.
//   Allocate scans the bitmap from word 0, one memory word per cycle, and
//   stops at the first word with a free bit; it reads between 1 and
//   NUM_WORDS words (32 at defaults). Release, mark and query read one
//   word and pass through accept/read, check/write-back and hand-off.
//   One command is in flight at a time.
//   After reset the store is cleared by a sweep over all NUM_WORDS words
//   (one word per cycle), during which s_axis_tready_o stays low.
//   The result sits in an output register; the next command is taken while
//   it waits. If the receiver stalls, a finished result is held in the
//   hand-off state until the output register frees, and no new command is
//   accepted meanwhile.
//   Release/mark/query of an index >= NUM_INDICES: out of range, no effect.
// ----------------------------------------------------------------------------
module bitmap_index_allocator_core #(
  parameter int unsigned NUM_INDICES = 1024,
  parameter int unsigned WORD_BITS   = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command: tdata = index[9:0], zero pad; tuser = operation[1:0]
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [bia_pkg::S_DATA_W-1:0]  s_axis_tdata_i,
  input  logic [bia_pkg::OP_W-1:0]      s_axis_tuser_i,
  // result: tdata = result_index[9:0], present[10], full_res[11],
  //         out_of_range[12], zero pad
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [bia_pkg::M_DATA_W-1:0]  m_axis_tdata_o
);

  localparam int unsigned NUM_WORDS = (NUM_INDICES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned PW        = $clog2(WORD_BITS);
  localparam int unsigned BASE_W    = $clog2(NUM_WORDS * WORD_BITS + 1);
  localparam int unsigned LAST_BITS = NUM_INDICES - (NUM_WORDS - 1) * WORD_BITS;
  // reciprocal for index / WORD_BITS, exact over the whole index range
  localparam int unsigned SH        = bia_pkg::IDX_W + $clog2(WORD_BITS) + 1;
  localparam int unsigned RECIP     = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
  localparam logic [AW-1:0] LAST_WORD = AW'(NUM_WORDS - 1);

  bia_pkg::bia_state_e state_q, state_d;

  logic [AW-1:0]            clr_q, clr_d;
  logic                     m_valid_q, m_valid_d;
  logic [bia_pkg::M_DATA_W-1:0] m_data_q;

  // command held during processing
  bia_pkg::bia_op_e         op_q;
  logic [bia_pkg::IDX_W-1:0] idx_q;
  logic [AW-1:0]            word_q;
  logic [PW-1:0]            bit_q;
  logic [BASE_W-1:0]        base_q;
  logic                     oor_q;

  // pending result
  logic [bia_pkg::IDX_W-1:0] res_idx_q;
  logic                     res_present_q, res_full_q, res_oor_q;

  // incoming command decode
  bia_pkg::bia_op_e         in_op;
  logic [bia_pkg::IDX_W-1:0] in_idx;
  logic [31:0]              div_prod, in_word, in_rem;
  logic                     in_oor;

  assign in_op    = bia_pkg::bia_op_e'(s_axis_tuser_i);
  assign in_idx   = s_axis_tdata_i[bia_pkg::IDX_W-1:0];
  assign div_prod = 32'(in_idx) * 32'(RECIP);
  assign in_word  = div_prod >> SH;
  assign in_rem   = 32'(in_idx) - in_word * 32'(WORD_BITS);
  assign in_oor   = 32'(in_idx) >= 32'(NUM_INDICES);

  // memory ports
  logic                  rd_en, wr_en;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic [WORD_BITS-1:0]  rd_data, wr_data;

  bia_ram #(
    .DEPTH  (NUM_WORDS),
    .WIDTH  (WORD_BITS),
    .ADDR_W (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // bits past NUM_INDICES in the last word never count as free
  logic [WORD_BITS-1:0] last_mask, scan_mask, free_vec;
  for (genvar b = 0; b < WORD_BITS; b++) begin : g_mask
    assign last_mask[b] = (b < LAST_BITS);
  end

  assign scan_mask = (word_q == LAST_WORD) ? last_mask : '1;
  assign free_vec  = ~rd_data & scan_mask;

  logic          found;
  logic [PW-1:0] free_pos;

  bia_ffs #(
    .WIDTH (WORD_BITS),
    .POS_W (PW)
  ) u_ffs (
    .vec_i   (free_vec),
    .found_o (found),
    .pos_o   (free_pos)
  );

  logic is_alloc, scan_more, out_free;
  logic [WORD_BITS-1:0] alloc_bit, op_bit;

  assign is_alloc  = (op_q == bia_pkg::OP_ALLOC);
  assign scan_more = is_alloc && !found && (word_q != LAST_WORD);
  assign out_free  = !m_valid_q || m_axis_tready_i;
  assign alloc_bit = WORD_BITS'(1) << free_pos;
  assign op_bit    = WORD_BITS'(1) << bit_q;

  // ---- next state ----
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bia_pkg::ST_CLEAR: if (clr_q == LAST_WORD) state_d = bia_pkg::ST_IDLE;
      bia_pkg::ST_IDLE:  if (s_axis_tvalid_i) state_d = bia_pkg::ST_CHECK;
      bia_pkg::ST_CHECK: if (!scan_more) state_d = bia_pkg::ST_RESP;
      bia_pkg::ST_RESP:  if (out_free) state_d = bia_pkg::ST_IDLE;
      default:           state_d = bia_pkg::ST_IDLE;
    endcase
  end

  // ---- memory control and result ----
  logic [bia_pkg::IDX_W-1:0] chk_idx;
  logic                      chk_present, chk_full, chk_oor;

  always_comb begin
    s_axis_tready_o = 1'b0;
    rd_en   = 1'b0;
    rd_addr = word_q + AW'(1);
    wr_en   = 1'b0;
    wr_addr = word_q;
    wr_data = rd_data;
    clr_d   = clr_q;
    chk_idx     = idx_q;
    chk_present = 1'b0;
    chk_full    = 1'b0;
    chk_oor     = 1'b0;
    unique case (state_q)
      bia_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
        clr_d   = clr_q + AW'(1);
      end
      bia_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        rd_en   = s_axis_tvalid_i;
        rd_addr = (in_op == bia_pkg::OP_ALLOC) ? '0 : AW'(in_word);
      end
      bia_pkg::ST_CHECK: begin
        if (is_alloc) begin
          rd_en = scan_more;
          if (found) begin
            wr_en   = 1'b1;
            wr_data = rd_data | alloc_bit;
            chk_idx = bia_pkg::IDX_W'(base_q + BASE_W'(free_pos));
          end else begin
            chk_idx  = '0;
            chk_full = 1'b1;
          end
        end else if (oor_q) begin
          chk_oor = 1'b1;
        end else begin
          chk_present = |(rd_data & op_bit);
          unique case (op_q)
            bia_pkg::OP_RELEASE: begin
              wr_en   = 1'b1;
              wr_data = rd_data & ~op_bit;
            end
            bia_pkg::OP_MARK: begin
              wr_en   = 1'b1;
              wr_data = rd_data | op_bit;
            end
            default: wr_en = 1'b0;
          endcase
        end
      end
      bia_pkg::ST_RESP: ;
      default: ;
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (m_axis_tready_i) m_valid_d = 1'b0;
    if (state_q == bia_pkg::ST_RESP && out_free) m_valid_d = 1'b1;
  end

  // ---- control registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bia_pkg::ST_CLEAR;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      m_valid_q <= m_valid_d;
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    if (state_q == bia_pkg::ST_IDLE && s_axis_tvalid_i) begin
      op_q   <= in_op;
      idx_q  <= in_idx;
      oor_q  <= in_oor;
      bit_q  <= PW'(in_rem);
      word_q <= (in_op == bia_pkg::OP_ALLOC) ? '0 : AW'(in_word);
      base_q <= '0;
    end else if (state_q == bia_pkg::ST_CHECK && scan_more) begin
      word_q <= word_q + AW'(1);
      base_q <= base_q + BASE_W'(WORD_BITS);
    end
    if (state_q == bia_pkg::ST_CHECK && !scan_more) begin
      res_idx_q     <= chk_idx;
      res_present_q <= chk_present;
      res_full_q    <= chk_full;
      res_oor_q     <= chk_oor;
    end
    if (state_q == bia_pkg::ST_RESP && out_free) begin
      m_data_q <= {3'b000, res_oor_q, res_full_q, res_present_q, res_idx_q};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // ---- assertions ----
  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == bia_pkg::ST_RESP))
    else $error("result word appeared without a hand-off");

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (wr_addr <= LAST_WORD))
    else $error("bitmap write beyond last word");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bia_pkg::ST_RESP && res_full_q) |->
      (res_idx_q == '0 && !res_present_q && !res_oor_q))
    else $error("full result carries stray fields");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bia_pkg::ST_CLEAR || state_q == bia_pkg::ST_CHECK) |-> !s_axis_tready_o)
    else $error("command accepted while busy");

endmodule

/* rtl/bia_ram.sv */
// ----------------------------------------------------------------------------
// bia_ram
// Bitmap store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bia_ram #(
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned ADDR_W = 5
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

/* rtl/bia_ffs.sv */
// ----------------------------------------------------------------------------
// bia_ffs
// Finds the lowest set bit of a word (set bit = free slot).
// ----------------------------------------------------------------------------
module bia_ffs #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned POS_W = 5
) (
  input  logic [WIDTH-1:0] vec_i,
  output logic             found_o,
  output logic [POS_W-1:0] pos_o
);

  always_comb begin
    pos_o = '0;
    for (int b = WIDTH - 1; b >= 0; b--) begin
      if (vec_i[b]) begin
        pos_o = POS_W'(b);
      end
    end
  end

  assign found_o = |vec_i;

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bitmap_index_allocator_core: drives command words
// (allocate, release, mark, query) on the slave stream and compares every
// result word with an in-bench first-fit predictor or the directed row's
// own expectation. Starts with a short directed table, then runs random
// traffic that fills the store to the full point and frees part of it
// again, under random idling on both streams and one long receiver stall.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned NUM_IDX     = 1024;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned NUM_WORDS   = NUM_IDX / WORD_W;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned TAIL_CYCLES = 48;   // longest scan plus hand-off, with margin
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct {
    logic [bia_pkg::IDX_W-1:0] res_index;
    logic                      present;
    logic                      full_res;
    logic                      out_of_range;
  } slot_result_t;

  typedef struct {
    bia_pkg::bia_op_e          op;
    logic [bia_pkg::IDX_W-1:0] index;
    bit                        typed;   // expectation written in the row itself
    slot_result_t              want;
  } cmd_row_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         s_axis_tvalid_i;
  logic                         s_axis_tready_o;
  logic [bia_pkg::S_DATA_W-1:0] s_axis_tdata_i;   // index[9:0], zero pad
  logic [bia_pkg::OP_W-1:0]     s_axis_tuser_i;   // operation[1:0]
  logic                         m_axis_tvalid_o;
  logic                         m_axis_tready_i;
  // result_index[9:0], present, full_res, out_of_range
  logic [bia_pkg::M_DATA_W-1:0] m_axis_tdata_o;

  // predictor state: one bit per index, packed in 32-bit words
  logic [WORD_W-1:0] used_words [NUM_WORDS];
  slot_result_t      due_results [$];
  cmd_row_t          dir_rows [$];

  bit          quiet;      // no idling on either side
  bit          hold_req;   // ask the receiver for one long stall
  int unsigned errors;
  int unsigned cycles;
  int unsigned n_cmds, n_allocs, n_results, n_refused, n_holds;

  bitmap_index_allocator_core #(
    .NUM_INDICES (NUM_IDX),
    .WORD_BITS   (WORD_W)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // first-fit bitmap step: updates used_words and returns the result word
  function automatic slot_result_t first_fit_step(bia_pkg::bia_op_e op,
                                                  logic [bia_pkg::IDX_W-1:0] idx);
    slot_result_t r;
    bit           found;
    r.res_index    = idx;
    r.present      = 1'b0;
    r.full_res     = 1'b0;
    r.out_of_range = 1'b0;
    found          = 1'b0;
    if (op == bia_pkg::OP_ALLOC) begin
      for (int w = 0; w < NUM_WORDS && !found; w++) begin
        for (int b = 0; b < WORD_W && !found; b++) begin
          if (!used_words[w][b]) begin
            used_words[w][b] = 1'b1;
            r.res_index      = bia_pkg::IDX_W'(w * WORD_W + b);
            found            = 1'b1;
          end
        end
      end
      if (!found) begin
        r.res_index = '0;
        r.full_res  = 1'b1;
      end
    end else if (int'(idx) >= NUM_IDX) begin
      r.out_of_range = 1'b1;
    end else begin
      r.present = used_words[idx / WORD_W][idx % WORD_W];
      if (op == bia_pkg::OP_RELEASE) used_words[idx / WORD_W][idx % WORD_W] = 1'b0;
      else if (op == bia_pkg::OP_MARK) used_words[idx / WORD_W][idx % WORD_W] = 1'b1;
    end
    return r;
  endfunction

  function automatic int unsigned lowest_free();
    for (int i = 0; i < NUM_IDX; i++) begin
      if (!used_words[i / WORD_W][i % WORD_W]) return i;
    end
    return NUM_IDX;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic bia_pkg::bia_op_e pick_op(int unsigned w_alloc, int unsigned w_rel,
                                               int unsigned w_mark);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < w_alloc) return bia_pkg::OP_ALLOC;
    if (r < w_alloc + w_rel) return bia_pkg::OP_RELEASE;
    if (r < w_alloc + w_rel + w_mark) return bia_pkg::OP_MARK;
    return bia_pkg::OP_QUERY;
  endfunction

  // mostly near the allocated region so that set bits get hit often
  function automatic logic [bia_pkg::IDX_W-1:0] pick_index();
    int unsigned r, span;
    r    = $urandom_range(0, 9);
    span = lowest_free() + 48;
    if (span > NUM_IDX - 1) span = NUM_IDX - 1;
    if (r == 0) return ($urandom_range(0, 1) != 0) ? bia_pkg::IDX_W'(NUM_IDX - 1) : '0;
    if (r < 4) return bia_pkg::IDX_W'($urandom_range(0, NUM_IDX - 1));
    return bia_pkg::IDX_W'($urandom_range(0, span));
  endfunction

  function automatic void add_row(bia_pkg::bia_op_e op, int unsigned idx, bit typed,
                                  int unsigned ridx = 0, bit pres = 0, bit full = 0);
    cmd_row_t row;
    row.op                = op;
    row.index             = bia_pkg::IDX_W'(idx);
    row.typed             = typed;
    row.want.res_index    = bia_pkg::IDX_W'(ridx);
    row.want.present      = pres;
    row.want.full_res     = full;
    row.want.out_of_range = 1'b0;
    dir_rows.push_back(row);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic issue_cmd(bia_pkg::bia_op_e op, logic [bia_pkg::IDX_W-1:0] idx,
                           bit typed, slot_result_t want);
    int unsigned  gap;
    slot_result_t got;
    gap = quiet ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = bia_pkg::S_DATA_W'(idx);
    s_axis_tuser_i  = op;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    got = first_fit_step(op, idx);
    due_results.push_back(typed ? want : got);
    n_cmds++;
    if (op == bia_pkg::OP_ALLOC) n_allocs++;
    @(negedge clk_i);
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    m_axis_tready_i = 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        m_axis_tready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
        n_holds++;
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        m_axis_tready_i = 1'b1;
        @(negedge clk_i);
      end else begin
        m_axis_tready_i = 1'b0;
        repeat (pick_gap() + 1) @(negedge clk_i);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin : result_check
    slot_result_t exp_r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      n_results++;
      if (due_results.size() == 0) begin
        $error("result word with nothing outstanding: tdata %h", m_axis_tdata_o);
        errors++;
      end else begin
        exp_r = due_results.pop_front();
        if (m_axis_tdata_o[bia_pkg::IDX_W-1:0] !== exp_r.res_index) begin
          $error("result_index: expected %0d, got %0d", exp_r.res_index,
                 m_axis_tdata_o[bia_pkg::IDX_W-1:0]);
          errors++;
        end
        if (m_axis_tdata_o[bia_pkg::IDX_W] !== exp_r.present) begin
          $error("present: expected %0b, got %0b", exp_r.present,
                 m_axis_tdata_o[bia_pkg::IDX_W]);
          errors++;
        end
        if (m_axis_tdata_o[bia_pkg::IDX_W+1] !== exp_r.full_res) begin
          $error("full_res: expected %0b, got %0b", exp_r.full_res,
                 m_axis_tdata_o[bia_pkg::IDX_W+1]);
          errors++;
        end
        if (m_axis_tdata_o[bia_pkg::IDX_W+2] !== exp_r.out_of_range) begin
          $error("out_of_range: expected %0b, got %0b", exp_r.out_of_range,
                 m_axis_tdata_o[bia_pkg::IDX_W+2]);
          errors++;
        end
        if (exp_r.full_res) n_refused++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("bitmap_index_allocator_core regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    slot_result_t     none;
    bia_pkg::bia_op_e op;
    none            = '{default: '0};
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = bia_pkg::OP_ALLOC;
    quiet           = 1'b0;
    hold_req        = 1'b0;
    errors          = 0;
    cycles          = 0;
    n_cmds          = 0;
    n_allocs        = 0;
    n_results       = 0;
    n_refused       = 0;
    n_holds         = 0;
    for (int w = 0; w < NUM_WORDS; w++) used_words[w] = '0;

    // directed table, starting from the empty store
    add_row(bia_pkg::OP_QUERY,   0,    1, 0,    0);
    add_row(bia_pkg::OP_ALLOC,   1023, 1, 0,    0);   // index field ignored
    add_row(bia_pkg::OP_ALLOC,   0,    1, 1,    0);
    add_row(bia_pkg::OP_QUERY,   1023, 1, 1023, 0);
    add_row(bia_pkg::OP_MARK,    1023, 1, 1023, 0);
    add_row(bia_pkg::OP_MARK,    1023, 1, 1023, 1);   // mark of a used index
    add_row(bia_pkg::OP_QUERY,   1023, 1, 1023, 1);
    add_row(bia_pkg::OP_RELEASE, 1023, 1, 1023, 1);
    add_row(bia_pkg::OP_RELEASE, 1023, 1, 1023, 0);   // release of a free index
    add_row(bia_pkg::OP_MARK,    2,    1, 2,    0);
    add_row(bia_pkg::OP_ALLOC,   0,    1, 3,    0);   // skips the marked bit
    add_row(bia_pkg::OP_RELEASE, 1,    1, 1,    1);
    add_row(bia_pkg::OP_ALLOC,   0,    1, 1,    0);   // refills the hole
    add_row(bia_pkg::OP_MARK,    0,    1, 0,    1);
    add_row(bia_pkg::OP_RELEASE, 0,    1, 0,    1);
    add_row(bia_pkg::OP_ALLOC,   0,    1, 0,    0);
    add_row(bia_pkg::OP_MARK,    31,   0);
    add_row(bia_pkg::OP_MARK,    32,   0);            // across the word boundary
    add_row(bia_pkg::OP_ALLOC,   0,    0);
    add_row(bia_pkg::OP_QUERY,   512,  0);
    add_row(bia_pkg::OP_MARK,    682,  0);
    add_row(bia_pkg::OP_RELEASE, 341,  0);
    add_row(bia_pkg::OP_ALLOC,   0,    0);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      issue_cmd(dir_rows[i].op, dir_rows[i].index, dir_rows[i].typed, dir_rows[i].want);
    end

    // random, allocation heavy; the long receiver stall lands in here
    for (int k = 0; k < 80; k++) begin
      if (k % 20 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (k == 30) hold_req = 1'b1;
      issue_cmd(pick_op(65, 15, 10), pick_index(), 1'b0, none);
    end

    // fill the store, then allocate past the full point
    quiet = 1'b0;
    while (lowest_free() < NUM_IDX) begin
      issue_cmd(bia_pkg::OP_ALLOC, pick_index(), 1'b0, none);
    end
    repeat (3) issue_cmd(bia_pkg::OP_ALLOC, pick_index(), 1'b0, none);
    repeat (3) begin
      issue_cmd(bia_pkg::OP_QUERY, bia_pkg::IDX_W'($urandom_range(0, NUM_IDX - 1)),
                1'b0, none);
      issue_cmd(bia_pkg::OP_RELEASE, bia_pkg::IDX_W'($urandom_range(0, NUM_IDX - 1)),
                1'b0, none);
      issue_cmd(bia_pkg::OP_ALLOC, '0, 1'b0, none);
      issue_cmd(bia_pkg::OP_ALLOC, '0, 1'b0, none);
    end

    // random, release heavy, freeing part of the full store again
    for (int k = 0; k < 24; k++) begin
      if (k % 12 == 0) quiet = ($urandom_range(0, 3) == 0);
      op = pick_op(15, 65, 10);
      issue_cmd(op, bia_pkg::IDX_W'($urandom_range(0, NUM_IDX - 1)), 1'b0, none);
    end
    s_axis_tvalid_i = 1'b0;
    quiet           = 1'b0;

    while (due_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Ran %0d commands (%0d allocations, %0d refused on a full store)",
             n_cmds, n_allocs, n_refused);
    $display("Checked %0d result words; long receiver stalls: %0d; errors: %0d",
             n_results, n_holds, errors);
    if (errors == 0 && due_results.size() == 0) begin
      $display("bitmap_index_allocator_core regression: pass");
    end else begin
      $display("bitmap_index_allocator_core regression: fail");
    end
    $finish;
  end

endmodule
